>>> sv/bsfr_pkg.sv
package bsfr_pkg;

   // Frame store geometry
   localparam int FRAME_DEPTH = 64;
   localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

   // Fixed field widths
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int CSR_IDX_W   = 2;

   localparam logic [LEN_W-1:0] DEPTH_COUNT = LEN_W'(FRAME_DEPTH);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_BYTE = 2'd2;

   // Configuration reset values
   localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd2;
   localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd3;
   localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd16;

   typedef enum logic [1:0] {
      ST_WAIT,
      ST_IN_FRAME,
      ST_ESCAPED,
      ST_DRAIN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_frame;
      logic keep_byte;
      logic drain_start;
      logic drain_advance;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_start;
      logic is_escape;
      logic is_end;
      logic drain_last;
   } status_type;

endpackage

>>> sv/bsfr_if.sv
interface bsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       is_last;
   logic [6:0] frame_length;
   logic       overflowed;
   logic       empty_frame;

   modport source (output valid, output payload_byte, output is_last, output frame_length,
                   output overflowed, output empty_frame, input ready);
   modport sink   (input valid, input payload_byte, input is_last, input frame_length,
                   input overflowed, input empty_frame, output ready);
endinterface

>>> sv/bsfr_ctrl.sv
module bsfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bsfr_pkg::status_type status,
   output bsfr_pkg::cmd_type    cmd
);
   import bsfr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_WAIT: begin
            req_ready = 1'b1;
            if (req_valid && status.is_start) begin
               cmd.clear_frame = 1'b1;
               state_in        = ST_IN_FRAME;
            end
         end
         ST_IN_FRAME: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority if (status.is_start) begin
                  cmd.clear_frame = 1'b1;
               end else if (status.is_escape) begin
                  state_in = ST_ESCAPED;
               end else if (status.is_end) begin
                  cmd.drain_start = 1'b1;
                  state_in        = ST_DRAIN;
               end else begin
                  cmd.keep_byte = 1'b1;
               end
            end
         end
         ST_ESCAPED: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.keep_byte = 1'b1;
               state_in      = ST_IN_FRAME;
            end
         end
         ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.drain_advance = 1'b1;
               if (status.drain_last) begin
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

endmodule

>>> sv/bsfr_dp.sv
module bsfr_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsfr_pkg::BYTE_W-1:0]  csr_wdata,
   input  logic [bsfr_pkg::BYTE_W-1:0]  rx_byte,
   input  bsfr_pkg::cmd_type            cmd,
   output bsfr_pkg::status_type         status,
   output logic [bsfr_pkg::BYTE_W-1:0]  payload_byte,
   output logic                         is_last,
   output logic [bsfr_pkg::LEN_W-1:0]   frame_length,
   output logic                         overflowed,
   output logic                         empty_frame
);
   import bsfr_pkg::*;

   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] end_byte_ff;
   logic [BYTE_W-1:0] escape_byte_ff;

   logic [BYTE_W-1:0] frame_store [FRAME_DEPTH];

   logic [LEN_W-1:0]  fill_ff;
   logic [LEN_W-1:0]  fill_in;
   logic              ovf_ff;
   logic              ovf_in;
   logic [LEN_W-1:0]  rd_idx_ff;
   logic [LEN_W-1:0]  rd_idx_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              store_full;
   logic              store_we;

   // Configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RST;
         end_byte_ff    <= END_BYTE_RST;
         escape_byte_ff <= ESCAPE_BYTE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_BYTE:  start_byte_ff  <= csr_wdata;
            CSR_END_BYTE:    end_byte_ff    <= csr_wdata;
            CSR_ESCAPE_BYTE: escape_byte_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign store_full = (fill_ff >= DEPTH_COUNT);
   assign store_we   = cmd.keep_byte && !store_full;

   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (cmd.clear_frame) begin
         fill_in = '0;
         ovf_in  = 1'b0;
      end else if (cmd.keep_byte) begin
         if (store_full) begin
            ovf_in = 1'b1;
         end else begin
            fill_in = fill_ff + LEN_W'(1);
         end
      end
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.drain_start) begin
         rd_idx_in = '0;
      end else if (cmd.drain_advance) begin
         rd_idx_in = rd_idx_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         ovf_ff    <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         ovf_ff    <= ovf_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // Frame store: one write port, one registered read port that prefetches the next index
   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_store[fill_ff[ADDR_W-1:0]] <= rx_byte;
      end
      rd_data_ff <= frame_store[rd_idx_in[ADDR_W-1:0]];
   end

   assign status.is_start   = (rx_byte == start_byte_ff);
   assign status.is_escape  = (rx_byte == escape_byte_ff);
   assign status.is_end     = (rx_byte == end_byte_ff);
   assign status.drain_last = (fill_ff == '0) || ((rd_idx_ff + LEN_W'(1)) == fill_ff);

   assign empty_frame  = (fill_ff == '0);
   assign payload_byte = empty_frame ? '0 : rd_data_ff;
   assign is_last      = status.drain_last;
   assign frame_length = fill_ff;
   assign overflowed   = ovf_ff;

endmodule

>>> sv/byte_stuffed_frame_receiver_unit.sv
// Channel   Direction  Handshake      Contents
// req_if    in         valid/ready    rx_byte: one raw byte from the link
// rsp_if    out        valid/ready    payload_byte, is_last, frame_length, overflowed,
//                                     empty_frame: one result per kept payload byte
// csr_*     in         write enable   csr_index selects start, end or escape byte
//
// Intake takes one request per cycle while a frame is being parsed.
// An end byte starts the drain: N results for N kept bytes (one for an empty frame),
// one per cycle while rsp_if.ready is high, read from the frame store through
// its single registered read port; requests are held off until the last result goes.
// Reset is synchronous, active high: parser waits for a start byte, count and
// overflow flag clear, registers return to 2, 3 and 16. The store itself is not cleared.
module byte_stuffed_frame_receiver_unit (
   input  logic                           clock,
   input  logic                           reset,
   bsfr_req_if.sink                       req_if,
   bsfr_rsp_if.source                     rsp_if,
   input  logic                           csr_write_en,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsfr_pkg::BYTE_W-1:0]    csr_wdata
);
   import bsfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: parse phase and drain sequencing
   bsfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: registers, byte compare, frame store, fill count and drain index
   bsfr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rx_byte      (req_if.rx_byte),
      .cmd          (cmd),
      .status       (status),
      .payload_byte (rsp_if.payload_byte),
      .is_last      (rsp_if.is_last),
      .frame_length (rsp_if.frame_length),
      .overflowed   (rsp_if.overflowed),
      .empty_frame  (rsp_if.empty_frame)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bsfr_pkg::*;

   // One expected output beat of a completed frame
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [LEN_W-1:0]  len;
      logic              ovf;
      logic              empty;
   } frame_result_type;

   // Directed script row: either a register write or one request byte.
   // A pinned row replaces whatever the predictor makes of it with the typed result.
   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [BYTE_W-1:0]    val;
      bit                   pinned;
      frame_result_type     typed;
   } script_row_type;

   localparam int SCRIPT_ROWS  = 33;
   localparam int PHASE_ITEMS  = 70;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_CYCLES = 8;
   localparam int TAIL_CYCLES  = 20;
   localparam int MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   bsfr_req_if req_if ();
   bsfr_rsp_if rsp_if ();

   byte_stuffed_frame_receiver_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the deframer: registers, parser phase, frame buffer
   logic [BYTE_W-1:0] start_reg  = START_BYTE_RST;
   logic [BYTE_W-1:0] end_reg    = END_BYTE_RST;
   logic [BYTE_W-1:0] escape_reg = ESCAPE_BYTE_RST;
   state_type         parse_st   = ST_WAIT;
   logic [BYTE_W-1:0] frame_buf [0:FRAME_DEPTH-1];
   logic [LEN_W-1:0]  kept_cnt   = '0;
   logic              ovf_seen   = 1'b0;

   frame_result_type frame_results_q [$];

   int mismatches    = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked    = 0;
   int hold_taken    = 0;
   int hold_left     = 0;

   // Directed script: reset registers first, then equal-register priority checks
   script_row_type script [0:SCRIPT_ROWS-1] = '{
      // idle byte while waiting: dropped
      '{1'b0, '0, 8'hFF, 1'b0, '0},
      // empty frame
      '{1'b0, '0, 8'h02, 1'b0, '0},
      '{1'b0, '0, 8'h03, 1'b1, '{8'h00, 1'b1, 7'd0, 1'b0, 1'b1}},
      // single zero byte
      '{1'b0, '0, 8'h02, 1'b0, '0},
      '{1'b0, '0, 8'h00, 1'b0, '0},
      '{1'b0, '0, 8'h03, 1'b1, '{8'h00, 1'b1, 7'd1, 1'b0, 1'b0}},
      // escaped start, end and escape bytes kept as data
      '{1'b0, '0, 8'h02, 1'b0, '0},
      '{1'b0, '0, 8'hFF, 1'b0, '0},
      '{1'b0, '0, 8'h10, 1'b0, '0},
      '{1'b0, '0, 8'h02, 1'b0, '0},
      '{1'b0, '0, 8'h10, 1'b0, '0},
      '{1'b0, '0, 8'h03, 1'b0, '0},
      '{1'b0, '0, 8'h10, 1'b0, '0},
      '{1'b0, '0, 8'h10, 1'b0, '0},
      '{1'b0, '0, 8'h03, 1'b0, '0},
      // second start byte drops the partial frame
      '{1'b0, '0, 8'h02, 1'b0, '0},
      '{1'b0, '0, 8'h55, 1'b0, '0},
      '{1'b0, '0, 8'h02, 1'b0, '0},
      '{1'b0, '0, 8'hAA, 1'b0, '0},
      '{1'b0, '0, 8'h03, 1'b1, '{8'hAA, 1'b1, 7'd1, 1'b0, 1'b0}},
      // all three registers equal: start wins inside a frame
      '{1'b1, CSR_START_BYTE,  8'h5A, 1'b0, '0},
      '{1'b1, CSR_END_BYTE,    8'h5A, 1'b0, '0},
      '{1'b1, CSR_ESCAPE_BYTE, 8'h5A, 1'b0, '0},
      '{1'b0, '0, 8'h5A, 1'b0, '0},
      '{1'b0, '0, 8'h11, 1'b0, '0},
      '{1'b0, '0, 8'h5A, 1'b0, '0},
      '{1'b0, '0, 8'h33, 1'b0, '0},
      // escape equal to end: escape wins, then the next byte is data
      '{1'b1, CSR_START_BYTE,  8'h01, 1'b0, '0},
      '{1'b0, '0, 8'h5A, 1'b0, '0},
      '{1'b0, '0, 8'h5A, 1'b0, '0},
      '{1'b0, '0, 8'h44, 1'b0, '0},
      // move the end byte and close the open frame
      '{1'b1, CSR_END_BYTE,    8'h03, 1'b0, '0},
      '{1'b0, '0, 8'h03, 1'b0, '0}
   };

   // Random phases: register settings and idling mix
   logic [BYTE_W-1:0] phase_start  [0:3] = '{8'h02, 8'h00, 8'hFF, 8'h7E};
   logic [BYTE_W-1:0] phase_end    [0:3] = '{8'h03, 8'hFF, 8'h00, 8'h7F};
   logic [BYTE_W-1:0] phase_escape [0:3] = '{8'h10, 8'h80, 8'h7F, 8'h7D};
   int                phase_idle   [0:3] = '{0, 58, 0, 37};
   int                phase_stall  [0:3] = '{0, 0, 58, 37};

   // Append one byte to the shadow frame, or flag overflow when full
   task automatic store_payload(input logic [BYTE_W-1:0] b);
      if (kept_cnt < DEPTH_COUNT) begin
         frame_buf[kept_cnt] = b;
         kept_cnt++;
      end else begin
         ovf_seen = 1'b1;
      end
   endtask

   // Advance the shadow parser by one accepted request byte and queue the
   // results it causes; made returns how many were queued.
   task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b, output int made);
      frame_result_type r;
      made = 0;
      case (parse_st)
         ST_IN_FRAME: begin
            // Priority on equal registers: start, then escape, then end
            if (b == start_reg) begin
               kept_cnt = '0;
               ovf_seen = 1'b0;
            end else if (b == escape_reg) begin
               parse_st = ST_ESCAPED;
            end else if (b == end_reg) begin
               parse_st = ST_WAIT;
               if (kept_cnt == '0) begin
                  r = '{8'h00, 1'b1, 7'd0, ovf_seen, 1'b1};
                  frame_results_q.push_back(r);
                  made = 1;
               end else begin
                  for (int k = 0; k < int'(kept_cnt); k++) begin
                     r.data  = frame_buf[k];
                     r.last  = (k == int'(kept_cnt) - 1);
                     r.len   = kept_cnt;
                     r.ovf   = ovf_seen;
                     r.empty = 1'b0;
                     frame_results_q.push_back(r);
                  end
                  made = int'(kept_cnt);
               end
            end else begin
               store_payload(b);
            end
         end
         ST_ESCAPED: begin
            // Anything after an escape is data
            store_payload(b);
            parse_st = ST_IN_FRAME;
         end
         default: begin
            if (b == start_reg) begin
               parse_st = ST_IN_FRAME;
               kept_cnt = '0;
               ovf_seen = 1'b0;
            end
         end
      endcase
   endtask

   // Offer one request byte from the falling edge, idling at random first;
   // return at the falling edge after the accepting rising edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, output int made);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.rx_byte = b;
      do @(posedge clock); while (!req_if.ready);
      absorb_rx_byte(b, made);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering, drain every pending result, let the block settle, then write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      req_if.valid = 1'b0;
      while (frame_results_q.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_START_BYTE:  start_reg  = val;
         CSR_END_BYTE:    end_reg    = val;
         CSR_ESCAPE_BYTE: escape_reg = val;
         default: ;
      endcase
   endtask

   // Send one stuffed frame of len data bytes. Unless tidy, sprinkle in line
   // noise before the start byte, restarts, and a missing end byte.
   task automatic send_frame(input int len, input bit tidy);
      logic [BYTE_W-1:0] d;
      int made;
      if (!tidy && $urandom_range(99) < 20) begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), made);
      end
      send_byte(start_reg, made);
      for (int i = 0; i < len; i++) begin
         if (!tidy && $urandom_range(99) < 3) send_byte(start_reg, made);
         d = 8'($urandom_range(255));
         // Stuff any byte that collides with a control value, plus a few others
         if (d == start_reg || d == end_reg || d == escape_reg || $urandom_range(99) < 8) begin
            send_byte(escape_reg, made);
         end
         send_byte(d, made);
      end
      if (tidy || $urandom_range(99) < 92) send_byte(end_reg, made);
   endtask

   // Response side: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken    <= hold_asked;
         hold_left     <= HOLD_CYCLES;
         rsp_if.ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready  <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Compare each accepted result with the oldest pending one
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (frame_results_q.size() == 0) begin
            note_mismatch({"result with nothing pending: ",
                           $sformatf("byte %02h last %0d len %0d ovf %0d empty %0d",
                                     rsp_if.payload_byte, rsp_if.is_last,
                                     rsp_if.frame_length, rsp_if.overflowed,
                                     rsp_if.empty_frame)});
         end else begin
            want = frame_results_q.pop_front();
            // Payload of an empty-frame result carries no meaning: skip it
            if (rsp_if.is_last !== want.last || rsp_if.frame_length !== want.len ||
                rsp_if.overflowed !== want.ovf || rsp_if.empty_frame !== want.empty ||
                (!want.empty && rsp_if.payload_byte !== want.data)) begin
               note_mismatch({$sformatf("expected byte %02h last %0d len %0d ovf %0d empty %0d",
                                        want.data, want.last, want.len, want.ovf,
                                        want.empty),
                              $sformatf(", got byte %02h last %0d len %0d ovf %0d empty %0d",
                                        rsp_if.payload_byte, rsp_if.is_last,
                                        rsp_if.frame_length, rsp_if.overflowed,
                                        rsp_if.empty_frame)});
            end
         end
      end
   end

   // Main sequence
   initial begin
      int made;
      int base;
      int roll;
      int len;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed script, starting from reset register values
      foreach (script[i]) begin
         if (script[i].is_csr) begin
            write_csr(script[i].idx, script[i].val);
         end else begin
            send_byte(script[i].val, made);
            // Swap the predicted beat for the hand-typed one
            if (script[i].pinned) begin
               repeat (made) void'(frame_results_q.pop_back());
               frame_results_q.push_back(script[i].typed);
            end
         end
      end

      // Random frames, one register setting and idling mix per phase
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_START_BYTE,  phase_start[p]);
         write_csr(CSR_END_BYTE,    phase_end[p]);
         write_csr(CSR_ESCAPE_BYTE, phase_escape[p]);
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         base = items_sent;
         while (items_sent - base < PHASE_ITEMS) begin
            // Mostly short frames, some medium, a few near or past the buffer depth
            roll = $urandom_range(99);
            if (roll < 85)      len = $urandom_range(12);
            else if (roll < 95) len = $urandom_range(40, 13);
            else                len = $urandom_range(FRAME_DEPTH + 6, FRAME_DEPTH - 4);
            send_frame(len, 1'b0);
         end
      end

      // Back-pressure: hold the response side off while the sender keeps
      // streaming, so the drain stalls and intake backs up
      write_csr(CSR_START_BYTE,  START_BYTE_RST);
      write_csr(CSR_END_BYTE,    END_BYTE_RST);
      write_csr(CSR_ESCAPE_BYTE, ESCAPE_BYTE_RST);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asked++;
      send_frame(FRAME_DEPTH - 14, 1'b1);
      send_frame(30, 1'b1);
      send_frame(FRAME_DEPTH + 6, 1'b1);
      req_if.valid = 1'b0;

      // Drain, then give the block time to show any stray result
      while (frame_results_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && frame_results_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
